// ===== rtl/core/x64ms_pkg.sv =====
// ----------------------------------------------------------------------------
// x64ms_pkg
// Shared types and encoding constants for the ModRM/SIB/REX encoder.
// ----------------------------------------------------------------------------
package x64ms_pkg;

  // Input word: one register-or-memory instruction form
  typedef struct packed {
    logic               size_prefix;
    logic               rex_w;
    logic [1:0]         opcode_count;
    logic [7:0]         opcode_first;
    logic [7:0]         opcode_second;
    logic [3:0]         reg_field;
    logic [1:0]         addressing_mode;
    logic [3:0]         rm_or_base_reg;
    logic [4:0]         index_reg;
    logic [1:0]         scale_code;
    logic signed [31:0] displacement;
    logic [1:0]         byte_reg_flags;
  } in_word_t;

  // Output word: one encoded byte
  typedef struct packed {
    logic [7:0] encoded_byte;
    logic       last_byte;
    logic       displacement_start;
    logic       encode_error;
  } out_word_t;

  // Fixed byte slots of one encoding, in emission order
  localparam int NUM_SLOTS = 10;
  localparam int SLOT_PFX  = 0;
  localparam int SLOT_REX  = 1;
  localparam int SLOT_OP1  = 2;
  localparam int SLOT_OP2  = 3;
  localparam int SLOT_MODRM = 4;
  localparam int SLOT_SIB  = 5;
  localparam int SLOT_D0   = 6;

  // Classified item: slot bytes, which slots are present, and flags
  typedef struct packed {
    logic [NUM_SLOTS-1:0][7:0] bytes;
    logic [NUM_SLOTS-1:0]      mask;
    logic                      rip;
    logic                      err;
  } plan_t;

  // Addressing mode codes
  localparam logic [1:0] MODE_REG    = 2'd0;
  localparam logic [1:0] MODE_BASE   = 2'd1;
  localparam logic [1:0] MODE_NOBASE = 2'd2;
  localparam logic [1:0] MODE_RIP    = 2'd3;

  // Encoding constants
  localparam logic [7:0] PFX_OPSIZE  = 8'h66;
  localparam logic [7:0] REX_BASE    = 8'h40;
  localparam logic [7:0] MOD_REG     = 8'hC0;
  localparam logic [7:0] MOD_DISP8   = 8'h40;
  localparam logic [7:0] MOD_DISP32  = 8'h80;
  localparam logic [7:0] MOD_NODISP  = 8'h00;
  localparam logic [2:0] RM_RIP      = 3'd5;
  localparam logic [2:0] RM_SIB      = 3'd4;
  localparam logic [2:0] SIB_NO_IDX  = 3'd4;
  localparam logic [2:0] SIB_NO_BASE = 3'd5;

endpackage

// ===== rtl/core/x64ms_front.sv =====
// ----------------------------------------------------------------------------
// x64ms_front
// Classifies one instruction form into a plan of up to ten slot bytes.
// ----------------------------------------------------------------------------
module x64ms_front import x64ms_pkg::*; (
  input  in_word_t word_i,
  output plan_t    plan_o
);

  logic       has_idx;
  logic [3:0] rex_bits;
  logic       rex_need;
  logic [7:0] r_bits;
  logic [2:0] idx_code;
  logic [2:0] base_lo;
  logic       disp_small;
  logic       disp_none;
  logic [7:0] mod_bits;

  // REX bits and error detection
  always_comb begin
    has_idx = ~word_i.index_reg[4];
    base_lo = word_i.rm_or_base_reg[2:0];
    rex_bits[3] = word_i.rex_w;
    rex_bits[2] = word_i.reg_field[3];
    rex_bits[1] = (word_i.addressing_mode == MODE_BASE ||
                   word_i.addressing_mode == MODE_NOBASE) &&
                  has_idx && word_i.index_reg[3];
    rex_bits[0] = (word_i.addressing_mode == MODE_REG ||
                   word_i.addressing_mode == MODE_BASE) &&
                  word_i.rm_or_base_reg[3];
    rex_need = (|rex_bits) | word_i.byte_reg_flags[0];
    r_bits   = {2'b00, word_i.reg_field[2:0], 3'b000};
    idx_code = has_idx ? word_i.index_reg[2:0] : SIB_NO_IDX;
  end

  // Displacement size for base memory form
  always_comb begin
    disp_none  = (word_i.displacement == '0) && (base_lo != RM_RIP);
    disp_small = (word_i.displacement[31:7] == '0) || (word_i.displacement[31:7] == '1);
    if (disp_none) begin
      mod_bits = MOD_NODISP;
    end else if (disp_small) begin
      mod_bits = MOD_DISP8;
    end else begin
      mod_bits = MOD_DISP32;
    end
  end

  // Slot bytes and presence mask
  always_comb begin
    plan_o       = '0;
    plan_o.err   = rex_need & word_i.byte_reg_flags[1];
    plan_o.rip   = (word_i.addressing_mode == MODE_RIP);

    plan_o.bytes[SLOT_PFX] = PFX_OPSIZE;
    plan_o.mask[SLOT_PFX]  = word_i.size_prefix;
    plan_o.bytes[SLOT_REX] = REX_BASE | {4'b0000, rex_bits};
    plan_o.mask[SLOT_REX]  = rex_need;
    plan_o.bytes[SLOT_OP1] = word_i.opcode_first;
    plan_o.mask[SLOT_OP1]  = 1'b1;
    plan_o.bytes[SLOT_OP2] = word_i.opcode_second;
    plan_o.mask[SLOT_OP2]  = word_i.opcode_count[1];
    for (int i = 0; i < 4; i++) begin
      plan_o.bytes[SLOT_D0+i] = word_i.displacement[8*i +: 8];
    end
    plan_o.mask[SLOT_MODRM] = 1'b1;

    case (word_i.addressing_mode)
      MODE_REG: begin
        plan_o.bytes[SLOT_MODRM] = MOD_REG | r_bits | {5'b00000, base_lo};
      end
      MODE_RIP: begin
        plan_o.bytes[SLOT_MODRM] = r_bits | {5'b00000, RM_RIP};
        plan_o.mask[SLOT_D0+3:SLOT_D0] = 4'hF;
      end
      MODE_NOBASE: begin
        plan_o.bytes[SLOT_MODRM] = r_bits | {5'b00000, RM_SIB};
        plan_o.bytes[SLOT_SIB]   = {word_i.scale_code, idx_code, SIB_NO_BASE};
        plan_o.mask[SLOT_SIB]    = 1'b1;
        plan_o.mask[SLOT_D0+3:SLOT_D0] = 4'hF;
      end
      default: begin
        // base memory; SIB when indexed or base is rsp/r12
        if (!has_idx && base_lo != RM_SIB) begin
          plan_o.bytes[SLOT_MODRM] = mod_bits | r_bits | {5'b00000, base_lo};
        end else begin
          plan_o.bytes[SLOT_MODRM] = mod_bits | r_bits | {5'b00000, RM_SIB};
          plan_o.bytes[SLOT_SIB]   = {word_i.scale_code, idx_code, base_lo};
          plan_o.mask[SLOT_SIB]    = 1'b1;
        end
        if (mod_bits == MOD_DISP8) begin
          plan_o.mask[SLOT_D0] = 1'b1;
        end else if (mod_bits == MOD_DISP32) begin
          plan_o.mask[SLOT_D0+3:SLOT_D0] = 4'hF;
        end
      end
    endcase
  end

endmodule

// ===== rtl/core/x64ms_queue.sv =====
// ----------------------------------------------------------------------------
// x64ms_queue
// Two-entry queue of classified plans between front and back.
// ----------------------------------------------------------------------------
module x64ms_queue import x64ms_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_i,
  input  plan_t plan_i,
  input  logic  pop_i,
  output plan_t head_o,
  output logic  full_o,
  output logic  empty_o
);

  plan_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_i;
    rd_ptr_nxt = rd_ptr_r ^ pop_i;
    count_nxt  = count_r + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= plan_i;
    end
  end

  assign head_o  = mem_r[rd_ptr_r];
  assign full_o  = (count_r == 2'd2);
  assign empty_o = (count_r == 2'd0);

endmodule

// ===== rtl/core/x64ms_back.sv =====
// ----------------------------------------------------------------------------
// x64ms_back
// Walks the present slots of the head plan, one byte per cycle while the
// output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module x64ms_back import x64ms_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  plan_t     head_i,
  input  logic      head_valid_i,
  output logic      pop_o,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic [NUM_SLOTS-1:0] done_r, done_nxt;
  logic [NUM_SLOTS-1:0] remain;
  logic [NUM_SLOTS-1:0] pick;
  logic                 last;
  logic [7:0]           sel_byte;
  logic                 load;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_word_r, out_word_nxt;

  // Lowest remaining slot and whether it is the final one
  always_comb begin
    remain   = head_i.mask & ~done_r;
    pick     = remain & (~remain + {{(NUM_SLOTS-1){1'b0}}, 1'b1});
    last     = ((remain & (remain - {{(NUM_SLOTS-1){1'b0}}, 1'b1})) == '0);
    sel_byte = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      sel_byte = sel_byte | (head_i.bytes[i] & {8{pick[i]}});
    end
  end

  // Advance when output register is free or being drained
  always_comb begin
    load  = head_valid_i && (!out_valid_r || !out_stall);
    pop_o = load && (head_i.err || last);

    done_nxt = done_r;
    if (pop_o) begin
      done_nxt = '0;
    end else if (load) begin
      done_nxt = done_r | pick;
    end

    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end

    out_word_nxt = out_word_r;
    if (load) begin
      out_word_nxt.encoded_byte       = head_i.err ? 8'h00 : sel_byte;
      out_word_nxt.last_byte          = head_i.err | last;
      out_word_nxt.displacement_start = !head_i.err && head_i.rip && pick[SLOT_D0];
      out_word_nxt.encode_error       = head_i.err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== rtl/core/x64_modrm_sib_encoder.sv =====
// ----------------------------------------------------------------------------
// x64_modrm_sib_encoder
// Encodes one x86-64 register-or-memory instruction form into a stream of
// bytes: 0x66, REX, opcode(s), ModRM, SIB and displacement as needed.
//
//   channel  direction  handshake         word
//   in_      input      in_valid/in_stall   in_word_t, one instruction form
//   out_     output     out_valid/out_stall out_word_t, one encoded byte
//
// One output word per cycle while out_stall is low; an item has as many output
// words as it has bytes (1 to 10), set by the back end's slot walker.
// Front classification is combinational into a two-entry queue, so items
// are taken while earlier ones are still being emitted.
// rst_n is synchronous, active low; it empties the queue and output register.
// out_stall holds the output register; in_stall rises only when the queue
// is full.
// ----------------------------------------------------------------------------
module x64_modrm_sib_encoder import x64ms_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  plan_t plan;
  plan_t head;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  logic  q_push;

  // Front: classify
  x64ms_front u_front (
    .word_i (in_word),
    .plan_o (plan)
  );

  assign q_push   = in_valid && !q_full;
  assign in_stall = q_full;

  // Queue between front and back
  x64ms_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .plan_i  (plan),
    .pop_i   (q_pop),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back: emit bytes
  x64ms_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_i       (head),
    .head_valid_i (!q_empty),
    .pop_o        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word)
  );

  // An error word always ends its item
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.encode_error |-> out_word.last_byte)
    else $error("error word not marked last");

  // An error word carries a zero byte and no patch mark
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.encode_error |->
      (out_word.encoded_byte == 8'h00) && !out_word.displacement_start)
    else $error("error word carries data");

  // Queue cannot be both full and empty
  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue occupancy inconsistent");

  // A pop only happens on a non-empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for x64_modrm_sib_encoder. A queue-fed driver sends
// instruction forms (a directed set of corner cases, then random forms); each
// accepted word is encoded by a local predictor into the expected byte words.
// A monitor compares every output word against the oldest expected one.
// Both sides idle at random, and the receiver holds off once for a long
// stretch so that the encoder backs up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;
  import x64ms_pkg::*;

  localparam int NUM_RANDOM  = 450;
  localparam int HOLD_START  = 400;   // cycle of the long receiver hold-off
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 20;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  in_word_t  form_queue [$];
  out_word_t expected_bytes [$];
  int        failures = 0;

  x64_modrm_sib_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Encoding predictor
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] value, input logic mark);
    out_word_t w;
    w = '0;
    w.encoded_byte       = value;
    w.displacement_start = mark;
    expected_bytes.push_back(w);
  endtask

  // little-endian disp32; only the first byte may carry the patch mark
  task automatic push_disp32(input logic [31:0] disp, input logic mark);
    push_byte(disp[7:0], mark);
    push_byte(disp[15:8], 1'b0);
    push_byte(disp[23:16], 1'b0);
    push_byte(disp[31:24], 1'b0);
  endtask

  task automatic encode_form(input in_word_t f);
    logic       has_idx;
    logic       needs_rex;
    logic [3:0] rex_bits;
    logic [2:0] idx_code;
    logic [2:0] base_lo;
    logic [7:0] r;
    logic [7:0] mod_bits;
    int         sd;
    out_word_t  tail;
    has_idx  = (f.index_reg < 5'd16);
    base_lo  = f.rm_or_base_reg[2:0];
    idx_code = has_idx ? f.index_reg[2:0] : SIB_NO_IDX;
    r        = {2'b00, f.reg_field[2:0], 3'b000};
    sd       = f.displacement;

    // REX bits: W R X B
    rex_bits[3] = f.rex_w;
    rex_bits[2] = f.reg_field[3];
    rex_bits[1] = (f.addressing_mode == MODE_BASE || f.addressing_mode == MODE_NOBASE)
                  && has_idx && f.index_reg[3];
    rex_bits[0] = (f.addressing_mode == MODE_REG || f.addressing_mode == MODE_BASE)
                  && f.rm_or_base_reg[3];
    needs_rex = (rex_bits != 4'd0) || f.byte_reg_flags[0];

    // AH..BH cannot be encoded next to a REX prefix
    if (needs_rex && f.byte_reg_flags[1]) begin
      tail = '0;
      tail.last_byte    = 1'b1;
      tail.encode_error = 1'b1;
      expected_bytes.push_back(tail);
      return;
    end

    if (f.size_prefix) push_byte(PFX_OPSIZE, 1'b0);
    if (needs_rex) push_byte(REX_BASE | {4'd0, rex_bits}, 1'b0);
    push_byte(f.opcode_first, 1'b0);
    if (f.opcode_count[1]) push_byte(f.opcode_second, 1'b0);

    case (f.addressing_mode)
      MODE_REG: begin
        push_byte(MOD_REG | r | {5'd0, base_lo}, 1'b0);
      end
      MODE_RIP: begin
        push_byte(MOD_NODISP | r | {5'd0, RM_RIP}, 1'b0);
        push_disp32(f.displacement, 1'b1);
      end
      MODE_NOBASE: begin
        push_byte(MOD_NODISP | r | {5'd0, RM_SIB}, 1'b0);
        push_byte({f.scale_code, idx_code, SIB_NO_BASE}, 1'b0);
        push_disp32(f.displacement, 1'b0);
      end
      default: begin
        // base 5 has no disp-free form, so it takes a zero disp8
        if (f.displacement == 32'd0 && base_lo != 3'd5) mod_bits = MOD_NODISP;
        else if (sd >= -128 && sd <= 127)                 mod_bits = MOD_DISP8;
        else                                              mod_bits = MOD_DISP32;
        if (!has_idx && base_lo != RM_SIB) begin
          push_byte(mod_bits | r | {5'd0, base_lo}, 1'b0);
        end else begin
          push_byte(mod_bits | r | {5'd0, RM_SIB}, 1'b0);
          push_byte({f.scale_code, idx_code, base_lo}, 1'b0);
        end
        if (mod_bits == MOD_DISP8)       push_byte(f.displacement[7:0], 1'b0);
        else if (mod_bits == MOD_DISP32) push_disp32(f.displacement, 1'b0);
      end
    endcase

    tail = expected_bytes.pop_back();
    tail.last_byte = 1'b1;
    expected_bytes.push_back(tail);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic in_word_t make_form(input logic [1:0] mode, input logic [3:0] regf,
                                         input logic [3:0] base, input logic [4:0] idx,
                                         input logic [1:0] sc, input logic [31:0] disp);
    in_word_t f;
    f = '0;
    f.opcode_count    = 2'd1;
    f.opcode_first    = 8'h8B;
    f.addressing_mode = mode;
    f.reg_field       = regf;
    f.rm_or_base_reg  = base;
    f.index_reg       = idx;
    f.scale_code      = sc;
    f.displacement    = disp;
    return f;
  endfunction

  function automatic logic [31:0] random_disp();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom_range(0, 255) - 128;
      2: begin
        case ($urandom_range(0, 5))
          0: return 32'd127;
          1: return 32'd128;
          2: return -32'sd128;
          3: return -32'sd129;
          4: return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic in_word_t random_form();
    in_word_t f;
    int       pick;
    f.size_prefix     = 1'($urandom_range(0, 1));
    f.rex_w           = 1'($urandom_range(0, 1));
    f.opcode_count    = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                                    : 2'($urandom_range(1, 2));
    f.opcode_first    = 8'($urandom_range(0, 255));
    f.opcode_second   = 8'($urandom_range(0, 255));
    f.reg_field       = 4'($urandom_range(0, 15));
    f.addressing_mode = 2'($urandom_range(0, 3));
    f.rm_or_base_reg  = 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 9);
    if (pick < 6)      f.index_reg = 5'($urandom_range(0, 15));
    else if (pick < 9) f.index_reg = 5'd16;
    else               f.index_reg = 5'($urandom_range(17, 31));
    f.scale_code      = 2'($urandom_range(0, 3));
    f.displacement    = random_disp();
    pick = $urandom_range(0, 19);
    if (pick < 14)      f.byte_reg_flags = 2'd0;
    else if (pick < 17) f.byte_reg_flags = 2'd1;
    else if (pick < 19) f.byte_reg_flags = 2'd2;
    else                f.byte_reg_flags = 2'd3;
    return f;
  endfunction

  // idle length: mostly short, a few long
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 14)      return $urandom_range(1, 3);
    else if (pick < 19) return $urandom_range(4, 12);
    else                return $urandom_range(20, 60);
  endfunction

  initial begin
    in_word_t f;
    // register direct, smallest and largest fields
    form_queue.push_back(make_form(MODE_REG, 4'd0, 4'd0, 5'd0, 2'd0, 32'd0));
    f = make_form(MODE_REG, 4'd15, 4'd15, 5'd31, 2'd3, 32'hFFFF_FFFF);
    f.size_prefix = 1'b1; f.rex_w = 1'b1; f.opcode_count = 2'd2;
    f.opcode_first = 8'hFF; f.opcode_second = 8'hFF;
    form_queue.push_back(f);
    // base memory: no disp, base 5 forced disp8, base 4 forced SIB
    form_queue.push_back(make_form(MODE_BASE, 4'd2, 4'd0, 5'd16, 2'd0, 32'd0));
    form_queue.push_back(make_form(MODE_BASE, 4'd1, 4'd5, 5'd16, 2'd0, 32'd0));
    form_queue.push_back(make_form(MODE_BASE, 4'd3, 4'd12, 5'd16, 2'd1, 32'd127));
    form_queue.push_back(make_form(MODE_BASE, 4'd9, 4'd13, 5'd16, 2'd0, -32'sd128));
    form_queue.push_back(make_form(MODE_BASE, 4'd0, 4'd1, 5'd16, 2'd0, 32'd128));
    form_queue.push_back(make_form(MODE_BASE, 4'd0, 4'd6, 5'd16, 2'd0, -32'sd129));
    form_queue.push_back(make_form(MODE_BASE, 4'd7, 4'd8, 5'd3, 2'd2, 32'h7FFF_FFFF));
    form_queue.push_back(make_form(MODE_BASE, 4'd7, 4'd3, 5'd11, 2'd3, 32'h8000_0000));
    // index four gives the no-index code; out-of-range index means none
    form_queue.push_back(make_form(MODE_BASE, 4'd4, 4'd2, 5'd4, 2'd3, 32'd5));
    form_queue.push_back(make_form(MODE_BASE, 4'd4, 4'd2, 5'd12, 2'd1, 32'd0));
    form_queue.push_back(make_form(MODE_BASE, 4'd5, 4'd2, 5'd31, 2'd2, 32'd0));
    // no-base: base ignored, REX.B stays clear
    form_queue.push_back(make_form(MODE_NOBASE, 4'd6, 4'd15, 5'd16, 2'd0, 32'd0));
    form_queue.push_back(make_form(MODE_NOBASE, 4'd14, 4'd8, 5'd9, 2'd2, 32'h1234_5678));
    // RIP-relative: base, index and scale ignored
    form_queue.push_back(make_form(MODE_RIP, 4'd0, 4'd15, 5'd9, 2'd3, 32'hFFFF_FFFF));
    form_queue.push_back(make_form(MODE_RIP, 4'd11, 4'd0, 5'd16, 2'd0, 32'd0));
    // byte registers: SPL..DIL alone, AH..BH without and with REX
    f = make_form(MODE_REG, 4'd6, 4'd4, 5'd16, 2'd0, 32'd0);
    f.byte_reg_flags = 2'd1; f.opcode_first = 8'h88;
    form_queue.push_back(f);
    f.byte_reg_flags = 2'd2;
    form_queue.push_back(f);
    f.byte_reg_flags = 2'd3;
    form_queue.push_back(f);
    f = make_form(MODE_BASE, 4'd4, 4'd1, 5'd16, 2'd0, 32'd0);
    f.byte_reg_flags = 2'd2; f.rex_w = 1'b1;
    form_queue.push_back(f);
    f = make_form(MODE_NOBASE, 4'd4, 4'd8, 5'd2, 2'd0, 32'd0);
    f.byte_reg_flags = 2'd2;
    form_queue.push_back(f);
    // opcode count outside 1..2
    f = make_form(MODE_REG, 4'd1, 4'd2, 5'd16, 2'd0, 32'd0);
    f.opcode_count = 2'd0; f.opcode_second = 8'hAA;
    form_queue.push_back(f);
    f.opcode_count = 2'd3; f.opcode_first = 8'h0F;
    form_queue.push_back(f);

    for (int i = 0; i < NUM_RANDOM; i++) form_queue.push_back(random_form());
  end

  // --------------------------------------------------------------------------
  // Reset and run control
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (form_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: offers queued forms with random gaps and quiet bursts
  // --------------------------------------------------------------------------
  int send_gap = 0;
  int send_burst = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) encode_form(in_word);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (form_queue.size() != 0) begin
          in_word  <= form_queue.pop_front();
          in_valid <= 1'b1;
          if (send_burst > 0) send_burst--;
          else if ($urandom_range(0, 39) == 0) send_burst = $urandom_range(20, 40);
          else if ($urandom_range(0, 2) == 0) send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall: random holds, quiet stretches, one long hold-off
  // --------------------------------------------------------------------------
  int stall_left = 0;
  int recv_calm = 0;
  int recv_cycle = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      recv_cycle++;
      if (recv_cycle == HOLD_START) begin
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0) begin
        if (recv_calm > 0) recv_calm--;
        else if ($urandom_range(0, 49) == 0) recv_calm = $urandom_range(20, 60);
        else if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: field-by-field compare against the oldest expected word
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual %h", $time, out_word);
        failures++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_word.encoded_byte !== want.encoded_byte) begin
          $display("%0t: encoded_byte: expected %h, actual %h",
                   $time, want.encoded_byte, out_word.encoded_byte);
          failures++;
        end
        if (out_word.last_byte !== want.last_byte) begin
          $display("%0t: last_byte: expected %b, actual %b",
                   $time, want.last_byte, out_word.last_byte);
          failures++;
        end
        if (out_word.displacement_start !== want.displacement_start) begin
          $display("%0t: displacement_start: expected %b, actual %b",
                   $time, want.displacement_start, out_word.displacement_start);
          failures++;
        end
        if (out_word.encode_error !== want.encode_error) begin
          $display("%0t: encode_error: expected %b, actual %b",
                   $time, want.encode_error, out_word.encode_error);
          failures++;
        end
      end
    end
  end

endmodule
